>>> rtl/core/blsd_pkg.sv
package blsd_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAX_SCALE  = 8;
  localparam int unsigned MAX_COLS   = 512;
  localparam int unsigned MAX_ROWS   = 4096;
  localparam int unsigned MAX_PLANES = 65535;

  localparam int unsigned SCALE_W  = 4;
  localparam int unsigned COLS_W   = 10;
  localparam int unsigned ROWS_W   = 13;
  localparam int unsigned PLANES_W = 16;

  localparam int unsigned SUBC_W = $clog2(MAX_SCALE);
  localparam int unsigned BCOL_W = $clog2(MAX_COLS);
  localparam int unsigned BROW_W = $clog2(MAX_ROWS);
  localparam int unsigned GRP_W  = SAMPLE_W + $clog2(MAX_SCALE);
  localparam int unsigned SUM_W  = SAMPLE_W + 2 * $clog2(MAX_SCALE);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_COLS   = 2'd1,
    CFG_ROWS   = 2'd2,
    CFG_PLANES = 2'd3
  } cfg_idx_e;

  // position info captured with each sample
  typedef struct packed {
    logic              first_col;
    logic              first_row;
    logic              group_end;
    logic              block_end;
    logic              eor;
    logic              eop;
    logic              eof;
    logic [BCOL_W-1:0] bcol;
  } pos_info_t;

endpackage

>>> rtl/core/block_sum_downsample_core.sv
// A result is registered when the request that ends its block leaves the input register.
// Throughput: one sample request per cycle; a waiting result only stalls the input
// once a second block-ending sample reaches the input register.
// Reset: scale 2, 1 column, 1 row, 1 plane; position counters and group sum cleared.
// The 512-entry column accumulator RAM is not cleared; entries are written before read.
// A register write also restarts the frame position.
module block_sum_downsample_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [blsd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [blsd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [blsd_pkg::SAMPLE_W-1:0] grad_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [blsd_pkg::SUM_W-1:0]   block_sum_o,
  output logic                                end_of_row_o,
  output logic                                end_of_plane_o,
  output logic                                end_of_frame_o
);
  import blsd_pkg::*;

  logic [SCALE_W-1:0]  scale_q;
  logic [COLS_W-1:0]   cols_q;
  logic [ROWS_W-1:0]   rows_q;
  logic [PLANES_W-1:0] planes_q;

  logic [SUBC_W-1:0]   subc_q;
  logic [BCOL_W-1:0]   bcol_q;
  logic [SUBC_W-1:0]   subr_q;
  logic [BROW_W-1:0]   brow_q;
  logic [PLANES_W-1:0] plane_q;

  logic col_last, bcol_last, subr_last, brow_last, plane_last;
  logic in_acc;

  pos_info_t                  pos_d, a_pos_q;
  logic                       a_valid_q;
  logic signed [SAMPLE_W-1:0] a_x_q;
  logic                       a_move;

  logic signed [SUM_W-1:0] col_mem [MAX_COLS];
  logic signed [SUM_W-1:0] rd_q;
  logic signed [GRP_W-1:0] grp_q, grp_d, x_ext;
  logic signed [SUM_W-1:0] total;
  logic                    mem_we;

  logic                    out_valid_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    eor_q, eop_q, eof_q;

  // position decode
  assign col_last   = ({1'b0, subc_q} + 1'b1) == scale_q;
  assign bcol_last  = ({1'b0, bcol_q} + 1'b1) == cols_q;
  assign subr_last  = ({1'b0, subr_q} + 1'b1) == scale_q;
  assign brow_last  = ({1'b0, brow_q} + 1'b1) == rows_q;
  assign plane_last = ({1'b0, plane_q} + 1'b1) == {1'b0, planes_q};

  always_comb begin
    pos_d.first_col = (subc_q == '0);
    pos_d.first_row = (subr_q == '0);
    pos_d.group_end = col_last;
    pos_d.block_end = col_last && subr_last;
    pos_d.eor       = bcol_last;
    pos_d.eop       = bcol_last && brow_last;
    pos_d.eof       = bcol_last && brow_last && plane_last;
    pos_d.bcol      = bcol_q;
  end

  assign a_move     = a_valid_q && (!a_pos_q.block_end || !out_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !a_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  // configuration, stored clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_W'(2);
      cols_q   <= COLS_W'(1);
      rows_q   <= ROWS_W'(1);
      planes_q <= PLANES_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SCALE: begin
          if (cfg_data_i[SCALE_W-1:0] == '0) scale_q <= SCALE_W'(1);
          else if (cfg_data_i[SCALE_W-1:0] > SCALE_W'(MAX_SCALE)) scale_q <= SCALE_W'(MAX_SCALE);
          else scale_q <= cfg_data_i[SCALE_W-1:0];
        end
        CFG_COLS: begin
          if (cfg_data_i[COLS_W-1:0] == '0) cols_q <= COLS_W'(1);
          else if (cfg_data_i[COLS_W-1:0] > COLS_W'(MAX_COLS)) cols_q <= COLS_W'(MAX_COLS);
          else cols_q <= cfg_data_i[COLS_W-1:0];
        end
        CFG_ROWS: begin
          if (cfg_data_i[ROWS_W-1:0] == '0) rows_q <= ROWS_W'(1);
          else if (cfg_data_i[ROWS_W-1:0] > ROWS_W'(MAX_ROWS)) rows_q <= ROWS_W'(MAX_ROWS);
          else rows_q <= cfg_data_i[ROWS_W-1:0];
        end
        CFG_PLANES: begin
          if (cfg_data_i[PLANES_W-1:0] == '0) planes_q <= PLANES_W'(1);
          else if (cfg_data_i[PLANES_W-1:0] > PLANES_W'(MAX_PLANES)) begin
            planes_q <= PLANES_W'(MAX_PLANES);
          end else planes_q <= cfg_data_i[PLANES_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // raster position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subc_q  <= '0;
      bcol_q  <= '0;
      subr_q  <= '0;
      brow_q  <= '0;
      plane_q <= '0;
    end else if (cfg_we_i) begin
      subc_q  <= '0;
      bcol_q  <= '0;
      subr_q  <= '0;
      brow_q  <= '0;
      plane_q <= '0;
    end else if (in_acc) begin
      if (!col_last) begin
        subc_q <= subc_q + 1'b1;
      end else begin
        subc_q <= '0;
        if (!bcol_last) begin
          bcol_q <= bcol_q + 1'b1;
        end else begin
          bcol_q <= '0;
          if (!subr_last) begin
            subr_q <= subr_q + 1'b1;
          end else begin
            subr_q <= '0;
            if (!brow_last) begin
              brow_q <= brow_q + 1'b1;
            end else begin
              brow_q <= '0;
              plane_q <= plane_last ? '0 : plane_q + 1'b1;
            end
          end
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_acc) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_x_q   <= grad_sample_i;
      a_pos_q <= pos_d;
    end
  end

  // accumulate
  assign x_ext = {{(GRP_W - SAMPLE_W){a_x_q[SAMPLE_W-1]}}, a_x_q};
  assign grp_d = a_pos_q.first_col ? x_ext : grp_q + x_ext;
  assign total = a_pos_q.first_row ? {{(SUM_W - GRP_W){grp_d[GRP_W-1]}}, grp_d}
                                   : rd_q + {{(SUM_W - GRP_W){grp_d[GRP_W-1]}}, grp_d};
  assign mem_we = a_move && a_pos_q.group_end && !a_pos_q.block_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
    end else if (cfg_we_i) begin
      grp_q <= '0;
    end else if (a_move) begin
      grp_q <= a_pos_q.group_end ? '0 : grp_d;
    end
  end

  // column accumulators; a write lands at least two requests before its read
  always_ff @(posedge clk_i) begin
    if (in_acc) rd_q <= col_mem[bcol_q];
    if (mem_we) col_mem[a_pos_q.bcol] <= total;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (a_move && a_pos_q.block_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move && a_pos_q.block_end) begin
      sum_q <= total;
      eor_q <= a_pos_q.eor;
      eop_q <= a_pos_q.eop;
      eof_q <= a_pos_q.eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign block_sum_o    = sum_q;
  assign end_of_row_o   = eor_q;
  assign end_of_plane_o = eop_q;
  assign end_of_frame_o = eof_q;

endmodule

>>> rtl/core/blsd_checker.sv
module blsd_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [blsd_pkg::SUM_W-1:0]    block_sum_o,
  input logic                                 end_of_row_o,
  input logic                                 end_of_plane_o,
  input logic                                 end_of_frame_o
);
  import blsd_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(block_sum_o)
      && $stable(end_of_frame_o))
    else $error("stalled result changed");

  // frame end implies plane end implies row end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> end_of_plane_o)
    else $error("frame end without plane end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_plane_o |-> end_of_row_o)
    else $error("plane end without row end");

  // input backpressure only when a result is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output free");

  // a new result only rises when the input was not stalled before it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_stall_o))
    else $error("result rose while input stalled");

endmodule

bind block_sum_downsample_core blsd_checker u_blsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .block_sum_o    (block_sum_o),
  .end_of_row_o   (end_of_row_o),
  .end_of_plane_o (end_of_plane_o),
  .end_of_frame_o (end_of_frame_o)
);

>>> tb/tb_block_sum_downsample_core.sv
module tb_block_sum_downsample_core;
  import blsd_pkg::*;

  localparam int unsigned ITEMS_GOAL  = 1900;
  localparam int unsigned CALM_ITEMS  = 300;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned DEAD_LIMIT  = 3000;
  localparam int unsigned SETTLE_CYC  = 6;

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_MAX,
    FILL_MIN
  } fill_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    eor;
    logic                    eop;
    logic                    eof;
  } blk_res_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_DATA_W-1:0] d [4];
    logic [SAMPLE_W-1:0]   smp;
    bit                    typed;
    blk_res_t              want;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  cfg_idx_e                   cfg_idx = CFG_SCALE;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] grad = '0;
  logic                       out_valid_o;
  logic                       out_stall = 1'b0;
  logic signed [SUM_W-1:0]    block_sum_o;
  logic                       end_of_row_o;
  logic                       end_of_plane_o;
  logic                       end_of_frame_o;

  block_sum_downsample_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .grad_sample_i  (grad),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .block_sum_o    (block_sum_o),
    .end_of_row_o   (end_of_row_o),
    .end_of_plane_o (end_of_plane_o),
    .end_of_frame_o (end_of_frame_o)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // block-sum predictor state
  logic [SCALE_W-1:0]      scale_reg = 4'd2;
  logic [COLS_W-1:0]       cols_reg = 10'd1;
  logic [ROWS_W-1:0]       rows_reg = 13'd1;
  logic [PLANES_W-1:0]     planes_reg = 16'd1;
  logic signed [SUM_W-1:0] col_acc [MAX_COLS];
  logic signed [GRP_W-1:0] grp_acc = '0;
  int unsigned             sub_col = 0;
  int unsigned             blk_col = 0;
  int unsigned             sub_row = 0;
  int unsigned             blk_row = 0;
  int unsigned             plane_idx = 0;

  blk_res_t    pending_sums [$];
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  bit          calm = 1'b0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  initial begin
    foreach (col_acc[k]) col_acc[k] = '0;
  end

  function automatic int unsigned clamp_cfg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void store_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_SCALE:  scale_reg = d[SCALE_W-1:0];
      CFG_COLS:   cols_reg = d[COLS_W-1:0];
      CFG_ROWS:   rows_reg = d[ROWS_W-1:0];
      CFG_PLANES: planes_reg = d[PLANES_W-1:0];
      default: ;
    endcase
    grp_acc = '0;
    sub_col = 0;
    blk_col = 0;
    sub_row = 0;
    blk_row = 0;
    plane_idx = 0;
  endfunction

  function automatic bit accumulate_sample(input logic signed [SAMPLE_W-1:0] x,
                                           output blk_res_t r);
    int unsigned             s;
    int unsigned             cols;
    int unsigned             rows;
    int unsigned             planes;
    logic signed [SUM_W-1:0] total;
    bit                      hit;
    s = clamp_cfg(scale_reg, MAX_SCALE);
    cols = clamp_cfg(cols_reg, MAX_COLS);
    rows = clamp_cfg(rows_reg, MAX_ROWS);
    planes = clamp_cfg(planes_reg, MAX_PLANES);
    hit = 1'b0;
    r = '0;
    if (sub_col == 0) grp_acc = x;
    else grp_acc = grp_acc + x;
    if (sub_col + 1 >= s) begin
      if (sub_row == 0) total = grp_acc;
      else total = col_acc[blk_col] + grp_acc;
      grp_acc = '0;
      if (sub_row + 1 >= s) begin
        r.sum = total;
        r.eor = (blk_col + 1 >= cols);
        r.eop = r.eor && (blk_row + 1 >= rows);
        r.eof = r.eop && (plane_idx + 1 >= planes);
        hit = 1'b1;
      end else begin
        col_acc[blk_col] = total;
      end
    end
    sub_col++;
    if (sub_col >= s) begin
      sub_col = 0;
      blk_col++;
      if (blk_col >= cols) begin
        blk_col = 0;
        sub_row++;
        if (sub_row >= s) begin
          sub_row = 0;
          blk_row++;
          if (blk_row >= rows) begin
            blk_row = 0;
            plane_idx++;
            if (plane_idx >= planes) plane_idx = 0;
          end
        end
      end
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 100) $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // one request per call; optional idle burst before it
  task automatic push_sample(input logic [SAMPLE_W-1:0] v, input bit typed,
                             input blk_res_t want);
    blk_res_t got;
    bit       hit;
    if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    grad <= v;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    hit = accumulate_sample(v, got);
    if (typed) pending_sums.push_back(want);
    else if (hit) pending_sums.push_back(got);
    items_sent++;
  endtask

  task automatic drain_results(input int unsigned extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] d_scale, d_cols, d_rows, d_planes);
    cfg_idx_e              order [4];
    logic [CFG_DATA_W-1:0] vals [4];
    order = '{CFG_SCALE, CFG_COLS, CFG_ROWS, CFG_PLANES};
    vals = '{d_scale, d_cols, d_rows, d_planes};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= order[i];
      cfg_data <= vals[i];
      @(posedge clk);
      store_reg(order[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 63)) - 16'd32;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic run_phase(input int unsigned s, c, r, p, n, input fill_e mode, input bit hold);
    logic [SAMPLE_W-1:0] v;
    drain_results(SETTLE_CYC);
    program_regs({12'($urandom()), 4'(s)}, {6'($urandom()), 10'(c)},
                 {3'($urandom()), 13'(r)}, 16'(p));
    quiet = hold || ($urandom_range(0, 3) == 0);
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (items_sent + CALM_ITEMS >= ITEMS_GOAL) calm = 1'b1;
      if (i == n / 2 && (hold || $urandom_range(0, 4) == 0)) drain_results(0);
      case (mode)
        FILL_MAX: v = 16'h7fff;
        FILL_MIN: v = 16'h8000;
        default:  v = pick_sample();
      endcase
      push_sample(v, 1'b0, '0);
    end
  endtask

  function automatic dir_row_t smp_row(input logic [SAMPLE_W-1:0] v);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.d = '{default: '0};
    row.smp = v;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t sum_row(input logic [SAMPLE_W-1:0] v, input int sum,
                                       input bit eor, eop, eof);
    dir_row_t row;
    row = smp_row(v);
    row.typed = 1'b1;
    row.want.sum = SUM_W'(sum);
    row.want.eor = eor;
    row.want.eop = eop;
    row.want.eof = eof;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_DATA_W-1:0] a, b, c, d);
    dir_row_t row;
    row = smp_row('0);
    row.is_cfg = 1'b1;
    row.d = '{a, b, c, d};
    return row;
  endfunction

  // receiver: random stall bursts, one long hold on request
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) stall_left--;
      else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (!calm && !quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin : check_out
    blk_res_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("unexpected block sum", block_sum_o, 0);
      end else begin
        want = pending_sums.pop_front();
        if (block_sum_o !== want.sum) report_mismatch("block_sum", block_sum_o, $signed(want.sum));
        if (end_of_row_o !== want.eor) report_mismatch("end_of_row", end_of_row_o, want.eor);
        if (end_of_plane_o !== want.eop) report_mismatch("end_of_plane", end_of_plane_o, want.eop);
        if (end_of_frame_o !== want.eof) report_mismatch("end_of_frame", end_of_frame_o, want.eof);
      end
    end
  end

  initial begin : watchdog
    int unsigned dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < DEAD_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) dead_cycles = 0;
      else dead_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    dir_row_t          dir_rows [$];
    int unsigned       s;
    int unsigned       c;
    int unsigned       r;
    int unsigned       p;
    int unsigned       n;
    int unsigned       pick;
    longint unsigned   frame;
    fill_e             mode;

    // reset geometry: one 2x2 block per frame
    repeat (3) dir_rows.push_back(smp_row(16'h7fff));
    dir_rows.push_back(sum_row(16'h7fff, 131068, 1'b1, 1'b1, 1'b1));
    repeat (3) dir_rows.push_back(smp_row(16'h8000));
    dir_rows.push_back(sum_row(16'h8000, -131072, 1'b1, 1'b1, 1'b1));
    // partial frame, then a write restarts the position
    dir_rows.push_back(smp_row(16'h0123));
    dir_rows.push_back(smp_row(16'h7fff));
    dir_rows.push_back(smp_row(16'h8000));
    // scale of zero acts as one: every sample is a block
    dir_rows.push_back(cfg_row(16'h0000, 16'h0002, 16'h0001, 16'h0002));
    dir_rows.push_back(sum_row(16'h7fff, 32767, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(sum_row(16'h8000, -32768, 1'b1, 1'b1, 1'b0));
    dir_rows.push_back(sum_row(16'h0001, 1, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(sum_row(16'hffff, -1, 1'b1, 1'b1, 1'b1));
    // two 2x2 blocks side by side
    dir_rows.push_back(cfg_row(16'h0002, 16'h0002, 16'h0001, 16'h0001));
    dir_rows.push_back(smp_row(16'h0100));
    dir_rows.push_back(smp_row(16'hff00));
    dir_rows.push_back(smp_row(16'h1234));
    dir_rows.push_back(smp_row(16'h8000));
    dir_rows.push_back(smp_row(16'h7fff));
    dir_rows.push_back(smp_row(16'h0001));
    dir_rows.push_back(smp_row(16'hedcb));
    dir_rows.push_back(smp_row(16'h0080));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        drain_results(SETTLE_CYC);
        program_regs(dir_rows[k].d[0], dir_rows[k].d[1], dir_rows[k].d[2], dir_rows[k].d[3]);
      end else begin
        push_sample(dir_rows[k].smp, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    // extremes of the settings and of the sums
    run_phase(15, 1, 1, 1, 64, FILL_MAX, 1'b0);
    run_phase(8, 1, 1, 1, 64, FILL_MIN, 1'b0);
    run_phase(1, 1023, 8191, 65535, 120, FILL_RANDOM, 1'b0);
    run_phase(0, 0, 0, 0, 40, FILL_RANDOM, 1'b0);
    run_phase(1, 4, 3, 2, 150, FILL_RANDOM, 1'b1);
    run_phase(2, 512, 4096, 65535, 80, FILL_RANDOM, 1'b0);

    while (items_sent < ITEMS_GOAL) begin
      pick = $urandom_range(0, 11);
      s = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 15) :
          (pick < 4) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      pick = $urandom_range(0, 11);
      c = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(513, 1023) :
          (pick == 2) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      pick = $urandom_range(0, 11);
      r = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(4097, 8191) : $urandom_range(1, 4);
      pick = $urandom_range(0, 11);
      p = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(60000, 65535) : $urandom_range(1, 3);
      frame = longint'(clamp_cfg(s, MAX_SCALE)) * clamp_cfg(s, MAX_SCALE) *
              clamp_cfg(c, MAX_COLS) * clamp_cfg(r, MAX_ROWS) * clamp_cfg(p, MAX_PLANES);
      if (frame <= 100) n = int'(frame) * $urandom_range(1, 3);
      else n = $urandom_range(40, 200);
      if (n > 200) n = 200;
      pick = $urandom_range(0, 9);
      mode = (pick == 0) ? FILL_MAX : (pick == 1) ? FILL_MIN : FILL_RANDOM;
      run_phase(s, c, r, p, n, mode, 1'b0);
    end

    drain_results(12);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
